[rtl/mtwg_pkg.sv]
// Shared types, widths and constants of the toggle wave generator.
package mtwg_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 10;
  localparam int unsigned COUNT_WIDTH_DEF  = 16;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned CH_W   = 4;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned ANG_W  = 8;
  localparam int unsigned US_W   = 16;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned ERR_W  = 2;
  localparam int unsigned CV_W   = 16;
  localparam int unsigned UNIT_W = 2;
  localparam int unsigned UCH_W  = 3;
  localparam int unsigned UE_W   = 3;

  localparam int unsigned MAX_CH      = 9;
  localparam int unsigned UNIT_A_LAST = 5;
  localparam int unsigned UNIT_B_LAST = 7;
  localparam int unsigned UNIT_B_BASE = 6;
  localparam int unsigned UNIT_C_BASE = 8;

  localparam logic [UNIT_W-1:0] UNIT_A = 2'd0;
  localparam logic [UNIT_W-1:0] UNIT_B = 2'd1;
  localparam logic [UNIT_W-1:0] UNIT_C = 2'd2;

  localparam logic [UE_W-1:0] UNIT_EN_RESET = 3'b111;

  localparam int unsigned SERVO_ANG_MAX  = 180;
  localparam int unsigned SERVO_US_MAX   = 19000;
  localparam int unsigned SERVO_FRAME_US = 20000;
  localparam int unsigned SERVO_BASE_US  = 1000;

  // angle * 555 / 100 as one multiply by 555 * ceil(2^19 / 100), then shift
  localparam int unsigned ANG_SCALE = 555 * 5243;
  localparam int unsigned ANG_SHIFT = 19;
  localparam int unsigned PROD_W    = 30;

  typedef enum logic [FUNC_W-1:0] {
    FN_START = 3'd0,
    FN_STOP  = 3'd1,
    FN_MATCH = 3'd2,
    FN_ANGLE = 3'd3,
    FN_US    = 3'd4
  } func_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_CHAN  = 2'd1,
    ERR_RANGE = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EXEC
  } ctrl_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CH_W-1:0]   channel;
    logic [HALF_W-1:0] first_half;
    logic [HALF_W-1:0] second_half;
    logic [ANG_W-1:0]  servo_angle;
    logic [US_W-1:0]   servo_us;
    logic [CNT_W-1:0]  counter_value;
  } item_t;

  typedef struct packed {
    logic [ERR_W-1:0]  error_code;
    logic              compare_write;
    logic [CV_W-1:0]   compare_value;
    logic [UNIT_W-1:0] timer_unit;
    logic [UCH_W-1:0]  unit_channel;
    logic              set_toggle_mode;
    logic              disable_channel;
  } result_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

[rtl/mtwg_item_if.sv]
// Input item channel of the toggle wave generator.
interface mtwg_item_if import mtwg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CH_W-1:0]   channel;
  logic [HALF_W-1:0] first_half;
  logic [HALF_W-1:0] second_half;
  logic [ANG_W-1:0]  servo_angle;
  logic [US_W-1:0]   servo_us;
  logic [CNT_W-1:0]  counter_value;

  modport source (
    output valid, func, channel, first_half, second_half, servo_angle, servo_us,
           counter_value,
    input  ready
  );
  modport sink (
    input  valid, func, channel, first_half, second_half, servo_angle, servo_us,
           counter_value,
    output ready
  );
endinterface

[rtl/mtwg_res_if.sv]
// Result channel of the toggle wave generator.
interface mtwg_res_if import mtwg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ERR_W-1:0]  error_code;
  logic              compare_write;
  logic [CV_W-1:0]   compare_value;
  logic [UNIT_W-1:0] timer_unit;
  logic [UCH_W-1:0]  unit_channel;
  logic              set_toggle_mode;
  logic              disable_channel;

  modport source (
    output valid, error_code, compare_write, compare_value, timer_unit, unit_channel,
           set_toggle_mode, disable_channel,
    input  ready
  );
  modport sink (
    input  valid, error_code, compare_write, compare_value, timer_unit, unit_channel,
           set_toggle_mode, disable_channel,
    output ready
  );
endinterface

[rtl/mtwg_cfg_if.sv]
// Configuration write channel for the unit enable register.
interface mtwg_cfg_if import mtwg_pkg::*;;
  logic            valid;
  logic            ready;
  logic [UE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/mtwg_ctrl.sv]
// Sequencer: accept a beat, run the servo conversion step, then execute.
module mtwg_ctrl import mtwg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CALC;
      end
      ST_CALC: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
      end
      ST_EXEC: begin
        cmd_o.exec = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

[rtl/mtwg_datapath.sv]
// Datapath: item register, servo conversion, channel stores and result register.
module mtwg_datapath import mtwg_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  input  item_t      item_i,
  mtwg_cfg_if.sink   cfg_i,
  mtwg_res_if.source res_o
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CMP_W = (COUNT_WIDTH < CV_W) ? COUNT_WIDTH : CV_W;
  localparam logic [CV_W-1:0] CMP_MASK = {CV_W{1'b1}} >> (CV_W - CMP_W);
  localparam logic [CH_W-1:0] CH_LIMIT = CH_W'(NUM_CHANNELS);

  item_t             item_q;
  logic [US_W-1:0]   svc_us_q, svc_us_d;
  logic [PROD_W-1:0] ang_prod;
  logic [UE_W-1:0]   unit_en_q;
  logic [HALF_W-1:0] hi_q [NUM_CHANNELS];
  logic [HALF_W-1:0] lo_q [NUM_CHANNELS];
  phase_e            ph_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] act_q;
  logic [NUM_CHANNELS-1:0] pend_q;
  result_t           res_q, res_d;
  logic              res_valid_q;

  logic [CH_W-1:0]   ch;
  logic [IDX_W-1:0]  idx;
  logic              ch_valid;
  logic [UNIT_W-1:0] unit;
  logic [UCH_W-1:0]  uch;
  logic [US_W-1:0]   servo_time;
  logic              rng_err;
  logic [HALF_W-1:0] start_hi, start_lo;
  logic              st_wr, ph_wr, act_set, act_clr, pend_set, pend_clr;
  logic [HALF_W-1:0] wr_hi, wr_lo;
  phase_e            wr_ph;
  func_e             fn;

  assign cfg_i.ready       = 1'b1;
  assign status_o.out_free = !res_valid_q || res_o.ready;

  assign ang_prod = PROD_W'(item_q.servo_angle) * PROD_W'(ANG_SCALE);
  assign svc_us_d = US_W'(ang_prod >> ANG_SHIFT) + US_W'(SERVO_BASE_US);

  assign fn  = func_e'(item_q.func);
  assign ch  = item_q.channel;
  assign idx = ch[IDX_W-1:0];

  always_comb begin
    if (ch <= CH_W'(UNIT_A_LAST)) begin
      unit = UNIT_A;
      uch  = ch[UCH_W-1:0];
    end else if (ch <= CH_W'(UNIT_B_LAST)) begin
      unit = UNIT_B;
      uch  = UCH_W'(ch - CH_W'(UNIT_B_BASE));
    end else begin
      unit = UNIT_C;
      uch  = UCH_W'(ch - CH_W'(UNIT_C_BASE));
    end
  end

  assign ch_valid = (ch < CH_LIMIT) && (ch <= CH_W'(MAX_CH)) && unit_en_q[unit];

  assign servo_time = (fn == FN_ANGLE) ? svc_us_q : item_q.servo_us;
  assign rng_err    = ((fn == FN_ANGLE) && (item_q.servo_angle > ANG_W'(SERVO_ANG_MAX))) ||
                      ((fn == FN_US) && (item_q.servo_us > US_W'(SERVO_US_MAX)));
  assign start_hi   = (fn == FN_START) ? item_q.first_half : servo_time;
  assign start_lo   = (fn == FN_START) ? item_q.second_half
                                       : US_W'(SERVO_FRAME_US) - servo_time;

  always_comb begin
    res_d    = '0;
    st_wr    = 1'b0;
    wr_hi    = '0;
    wr_lo    = '0;
    ph_wr    = 1'b0;
    wr_ph    = PH_IDLE;
    act_set  = 1'b0;
    act_clr  = 1'b0;
    pend_set = 1'b0;
    pend_clr = 1'b0;
    unique case (fn) inside
      FN_START, FN_ANGLE, FN_US: begin
        if (rng_err) begin
          res_d.error_code = ERR_RANGE;
        end else if (!ch_valid) begin
          res_d.error_code = ERR_CHAN;
        end else begin
          st_wr                 = 1'b1;
          wr_hi                 = start_hi;
          wr_lo                 = start_lo;
          ph_wr                 = 1'b1;
          wr_ph                 = PH_IDLE;
          act_set               = 1'b1;
          pend_clr              = 1'b1;
          res_d.compare_write   = 1'b1;
          res_d.compare_value   = start_hi & CMP_MASK;
          res_d.timer_unit      = unit;
          res_d.unit_channel    = uch;
          res_d.set_toggle_mode = 1'b1;
        end
      end
      FN_STOP: begin
        if (!ch_valid) begin
          res_d.error_code = ERR_CHAN;
        end else begin
          res_d.timer_unit   = unit;
          res_d.unit_channel = uch;
          if (act_q[idx]) begin
            if (ph_q[idx] == PH_SECOND) begin
              st_wr                 = 1'b1;
              ph_wr                 = 1'b1;
              act_clr               = 1'b1;
              pend_clr              = 1'b1;
              res_d.disable_channel = 1'b1;
            end else begin
              pend_set = 1'b1;
            end
          end
        end
      end
      FN_MATCH: begin
        if (!ch_valid) begin
          res_d.error_code = ERR_CHAN;
        end else begin
          res_d.timer_unit   = unit;
          res_d.unit_channel = uch;
          if (act_q[idx]) begin
            if (ph_q[idx] == PH_SECOND) begin
              ph_wr               = 1'b1;
              wr_ph               = PH_FIRST;
              res_d.compare_write = 1'b1;
              res_d.compare_value = CV_W'(item_q.counter_value + hi_q[idx]) & CMP_MASK;
            end else if (pend_q[idx]) begin
              st_wr                 = 1'b1;
              ph_wr                 = 1'b1;
              act_clr               = 1'b1;
              pend_clr              = 1'b1;
              res_d.disable_channel = 1'b1;
            end else begin
              ph_wr               = 1'b1;
              wr_ph               = PH_SECOND;
              res_d.compare_write = 1'b1;
              res_d.compare_value = CV_W'(item_q.counter_value + lo_q[idx]) & CMP_MASK;
            end
          end
        end
      end
      default: begin
        res_d.error_code = ERR_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (cmd_i.calc) svc_us_q <= svc_us_d;
    if (cmd_i.exec) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_en_q <= UNIT_EN_RESET;
    end else if (cfg_i.valid) begin
      unit_en_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        hi_q[i] <= '0;
        lo_q[i] <= '0;
        ph_q[i] <= PH_IDLE;
      end
      act_q  <= '0;
      pend_q <= '0;
    end else if (cmd_i.exec) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (IDX_W'(i) == idx) begin
          if (st_wr) begin
            hi_q[i] <= wr_hi;
            lo_q[i] <= wr_lo;
          end
          if (ph_wr) ph_q[i] <= wr_ph;
          if (act_set) act_q[i] <= 1'b1;
          if (act_clr) act_q[i] <= 1'b0;
          if (pend_set) pend_q[i] <= 1'b1;
          if (pend_clr) pend_q[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.error_code      = res_q.error_code;
  assign res_o.compare_write   = res_q.compare_write;
  assign res_o.compare_value   = res_q.compare_value;
  assign res_o.timer_unit      = res_q.timer_unit;
  assign res_o.unit_channel    = res_q.unit_channel;
  assign res_o.set_toggle_mode = res_q.set_toggle_mode;
  assign res_o.disable_channel = res_q.disable_channel;

endmodule

[rtl/multichannel_toggle_wave_generator_unit.sv]
// A result is registered in exec, after the calc state. A new item is taken
// only after the last executes (accept, servo multiply, execute in the
// sequencer); execute holds while the output register is full and not taken.
// Reset clears all channel stores, active and pending-stop masks and the result
// valid flag; unit enable resets to all units on. No clearing pass is needed.
module multichannel_toggle_wave_generator_unit import mtwg_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mtwg_item_if.sink   item_i,
  mtwg_res_if.source  result_o,
  mtwg_cfg_if.sink    cfg_i
);

  dp_cmd_t    cmd;
  dp_status_t status;
  item_t      item;
  logic       in_ready;

  assign item_i.ready = in_ready;

  assign item = '{
    func:          item_i.func,
    channel:       item_i.channel,
    first_half:    item_i.first_half,
    second_half:   item_i.second_half,
    servo_angle:   item_i.servo_angle,
    servo_us:      item_i.servo_us,
    counter_value: item_i.counter_value
  };

  mtwg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mtwg_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .item_i   (item),
    .cfg_i    (cfg_i),
    .res_o    (result_o)
  );

endmodule

[tb/tb_multichannel_toggle_wave_generator_unit.sv]
// Self-checking testbench for the ten-channel toggle wave generator unit.
`timescale 1ns / 100ps

module tb_multichannel_toggle_wave_generator_unit;
  import mtwg_pkg::*;

  localparam int unsigned ANG_NUM        = 555;
  localparam int unsigned ANG_DEN        = 100;
  localparam int unsigned NCH            = 10;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned HOLD_AT_ITEM   = 400;
  localparam int unsigned QUIET_FROM     = 900;
  localparam int unsigned QUIET_TO       = 1200;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned MAX_PRINTS     = 40;
  localparam int unsigned TAIL_CYCLES    = 12;

  localparam logic [FUNC_W-1:0] FN_UNKNOWN_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNKNOWN_HI = 3'd7;

  logic clk_i;
  logic rst_ni;

  mtwg_item_if item_if ();
  mtwg_res_if  res_if ();
  mtwg_cfg_if  cfg_if ();

  multichannel_toggle_wave_generator_unit uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  // channel model
  logic [HALF_W-1:0] hi_ticks [NCH];
  logic [HALF_W-1:0] lo_ticks [NCH];
  phase_e            ch_phase [NCH];
  logic [NCH-1:0]    active_bits;
  logic [NCH-1:0]    stop_bits;
  logic [UE_W-1:0]   unit_en_model;

  item_t   pending_items[$];
  result_t expected_results[$];

  bit item_taken;
  int unsigned n_items, n_results, n_cfg, n_writes, n_disables, n_errors_seen;
  int unsigned mismatches, stall_cycles;
  bit quiet;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  assign quiet = (n_items >= QUIET_FROM) && (n_items < QUIET_TO);

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic logic map_channel(input logic [CH_W-1:0] ch, output logic [UNIT_W-1:0] unit,
                                       output logic [UCH_W-1:0] uch);
    unit = '0;
    uch  = '0;
    if (ch > MAX_CH) return 1'b0;
    if (ch <= UNIT_A_LAST) begin
      unit = UNIT_A;
      uch  = ch[UCH_W-1:0];
    end else if (ch <= UNIT_B_LAST) begin
      unit = UNIT_B;
      uch  = UCH_W'(ch - UNIT_B_BASE);
    end else begin
      unit = UNIT_C;
      uch  = UCH_W'(ch - UNIT_C_BASE);
    end
    if (!unit_en_model[unit]) begin
      unit = '0;
      uch  = '0;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void retire_channel(input int c, inout result_t r);
    active_bits[c]   = 1'b0;
    stop_bits[c]     = 1'b0;
    ch_phase[c]      = PH_IDLE;
    hi_ticks[c]      = '0;
    lo_ticks[c]      = '0;
    r.disable_channel = 1'b1;
  endfunction

  function automatic void arm_channel(input logic [CH_W-1:0] ch, input logic [HALF_W-1:0] h1,
                                      input logic [HALF_W-1:0] h2, inout result_t r);
    logic [UNIT_W-1:0] unit;
    logic [UCH_W-1:0]  uch;
    if (!map_channel(ch, unit, uch)) begin
      r.error_code = ERR_CHAN;
      return;
    end
    hi_ticks[ch]      = h1;
    lo_ticks[ch]      = h2;
    ch_phase[ch]      = PH_IDLE;
    active_bits[ch]   = 1'b1;
    stop_bits[ch]     = 1'b0;
    r.compare_write   = 1'b1;
    r.compare_value   = h1;
    r.timer_unit      = unit;
    r.unit_channel    = uch;
    r.set_toggle_mode = 1'b1;
  endfunction

  function automatic result_t predict_result(input item_t it);
    result_t           r;
    logic [UNIT_W-1:0] unit;
    logic [UCH_W-1:0]  uch;
    logic [HALF_W-1:0] us;
    int                c;
    r = '0;
    c = it.channel;
    case (it.func)
      FN_START: arm_channel(it.channel, it.first_half, it.second_half, r);
      FN_ANGLE: begin
        if (it.servo_angle > SERVO_ANG_MAX) begin
          r.error_code = ERR_RANGE;
        end else begin
          us = HALF_W'((int'(it.servo_angle) * ANG_NUM) / ANG_DEN + SERVO_BASE_US);
          arm_channel(it.channel, us, HALF_W'(SERVO_FRAME_US - us), r);
        end
      end
      FN_US: begin
        if (it.servo_us > SERVO_US_MAX) begin
          r.error_code = ERR_RANGE;
        end else begin
          arm_channel(it.channel, it.servo_us, HALF_W'(SERVO_FRAME_US - it.servo_us), r);
        end
      end
      FN_STOP, FN_MATCH: begin
        if (!map_channel(it.channel, unit, uch)) begin
          r.error_code = ERR_CHAN;
        end else begin
          r.timer_unit   = unit;
          r.unit_channel = uch;
          if (active_bits[c]) begin
            if (it.func == FN_STOP) begin
              if (ch_phase[c] == PH_SECOND) retire_channel(c, r);
              else stop_bits[c] = 1'b1;
            end else if (ch_phase[c] == PH_SECOND) begin
              r.compare_write = 1'b1;
              r.compare_value = it.counter_value + hi_ticks[c];
              ch_phase[c]     = PH_FIRST;
            end else if (stop_bits[c]) begin
              retire_channel(c, r);
            end else begin
              r.compare_write = 1'b1;
              r.compare_value = it.counter_value + lo_ticks[c];
              ch_phase[c]     = PH_SECOND;
            end
          end
        end
      end
      default: r.error_code = ERR_RANGE;
    endcase
    return r;
  endfunction

  function automatic item_t mk_item(input logic [FUNC_W-1:0] func, input logic [CH_W-1:0] ch,
                                    input logic [HALF_W-1:0] h1, input logic [HALF_W-1:0] h2,
                                    input logic [ANG_W-1:0] ang, input logic [US_W-1:0] us,
                                    input logic [CNT_W-1:0] cnt);
    item_t it;
    it.func          = func;
    it.channel       = ch;
    it.first_half    = h1;
    it.second_half   = h2;
    it.servo_angle   = ang;
    it.servo_us      = us;
    it.counter_value = cnt;
    return it;
  endfunction

  function automatic logic [CH_W-1:0] pick_channel();
    if ($urandom_range(99, 0) < 90) return CH_W'($urandom_range(MAX_CH, 0));
    return CH_W'($urandom_range(15, MAX_CH + 1));
  endfunction

  function automatic item_t random_item(input logic [FUNC_W-1:0] func, input logic [CH_W-1:0] ch);
    item_t it;
    it = mk_item(func, ch, HALF_W'($urandom()), HALF_W'($urandom()), ANG_W'($urandom()),
                 US_W'($urandom()), CNT_W'($urandom()));
    if (func == FN_ANGLE && $urandom_range(99, 0) < 85)
      it.servo_angle = ANG_W'($urandom_range(SERVO_ANG_MAX, 0));
    if (func == FN_US && $urandom_range(99, 0) < 85)
      it.servo_us = US_W'($urandom_range(SERVO_US_MAX, 0));
    return it;
  endfunction

  function automatic int add_single();
    int unsigned roll;
    logic [FUNC_W-1:0] func;
    roll = $urandom_range(99, 0);
    if (roll < 14) func = FN_START;
    else if (roll < 24) func = FN_STOP;
    else if (roll < 72) func = FN_MATCH;
    else if (roll < 82) func = FN_ANGLE;
    else if (roll < 92) func = FN_US;
    else if (roll < 95) func = FUNC_W'($urandom_range(FN_UNKNOWN_HI, FN_UNKNOWN_LO));
    else func = FN_MATCH;
    pending_items.push_back(random_item(func, pick_channel()));
    return 1;
  endfunction

  function automatic int add_wave_burst();
    logic [CH_W-1:0]   ch;
    logic [FUNC_W-1:0] arm;
    int                n, cnt;
    int unsigned       roll;
    ch   = pick_channel();
    roll = $urandom_range(99, 0);
    arm  = (roll < 70) ? FN_START : (roll < 85) ? FN_ANGLE : FN_US;
    pending_items.push_back(random_item(arm, ch));
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++) pending_items.push_back(random_item(FN_MATCH, ch));
    pending_items.push_back(random_item(FN_STOP, ch));
    cnt = $urandom_range(2, 1);
    for (int i = 0; i < cnt; i++) pending_items.push_back(random_item(FN_MATCH, ch));
    return n + cnt + 2;
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || item_if.valid || expected_results.size() != 0);
  endtask

  task automatic write_unit_enable(input logic [UE_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i);
    while (!(cfg_if.valid && cfg_if.ready));
    unit_en_model = v;
    n_cfg++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // item driver: hold the beat until taken, then offer the next one
  always @(negedge clk_i) begin
    item_t it;
    if (rst_ni && (!item_if.valid || item_taken)) begin
      item_taken = 1'b0;
      if (pending_items.size() != 0 && (quiet || $urandom_range(99, 0) >= 7)) begin
        it = pending_items.pop_front();
        item_if.valid         <= 1'b1;
        item_if.func          <= it.func;
        item_if.channel       <= it.channel;
        item_if.first_half    <= it.first_half;
        item_if.second_half   <= it.second_half;
        item_if.servo_angle   <= it.servo_angle;
        item_if.servo_us      <= it.servo_us;
        item_if.counter_value <= it.counter_value;
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // result sink with one long hold-off
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left    = 0;
    held         = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && n_items >= HOLD_AT_ITEM) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= quiet || ($urandom_range(99, 0) >= 7);
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    item_t   it;
    result_t got, want;
    bit      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (item_if.valid && item_if.ready) begin
        it = mk_item(item_if.func, item_if.channel, item_if.first_half, item_if.second_half,
                     item_if.servo_angle, item_if.servo_us, item_if.counter_value);
        expected_results.push_back(predict_result(it));
        item_taken = 1'b1;
        n_items++;
        moved = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        moved = 1'b1;
        n_results++;
        got.error_code      = res_if.error_code;
        got.compare_write   = res_if.compare_write;
        got.compare_value   = res_if.compare_value;
        got.timer_unit      = res_if.timer_unit;
        got.unit_channel    = res_if.unit_channel;
        got.set_toggle_mode = res_if.set_toggle_mode;
        got.disable_channel = res_if.disable_channel;
        if (expected_results.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = expected_results.pop_front();
          check_field("error_code", got.error_code, want.error_code);
          check_field("compare_write", got.compare_write, want.compare_write);
          check_field("compare_value", got.compare_value, want.compare_value);
          check_field("timer_unit", got.timer_unit, want.timer_unit);
          check_field("unit_channel", got.unit_channel, want.unit_channel);
          check_field("set_toggle_mode", got.set_toggle_mode, want.set_toggle_mode);
          check_field("disable_channel", got.disable_channel, want.disable_channel);
          if (want.compare_write) n_writes++;
          if (want.disable_channel) n_disables++;
          if (want.error_code != ERR_NONE) n_errors_seen++;
        end
      end
      if (cfg_if.valid && cfg_if.ready) moved = 1'b1;
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", stall_cycles);
        $display("multichannel_toggle_wave_generator_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    logic [UE_W-1:0] settings [11];
    int              added;
    settings = '{3'd0, 3'd7, 3'd1, 3'd2, 3'd4, 3'd6, 3'd5, 3'd3, 3'd0, 3'd0, 3'd0};
    for (int i = 8; i < 11; i++) settings[i] = UE_W'($urandom());

    rst_ni               = 1'b0;
    item_taken           = 1'b0;
    item_if.valid        = 1'b0;
    item_if.func         = '0;
    item_if.channel      = '0;
    item_if.first_half   = '0;
    item_if.second_half  = '0;
    item_if.servo_angle  = '0;
    item_if.servo_us     = '0;
    item_if.counter_value = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.data          = '0;
    unit_en_model        = UNIT_EN_RESET;
    active_bits          = '0;
    stop_bits            = '0;
    for (int c = 0; c < NCH; c++) begin
      hi_ticks[c] = '0;
      lo_ticks[c] = '0;
      ch_phase[c] = PH_IDLE;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // wrap, deferred stop, immediate stop, ignored items
    pending_items.push_back(mk_item(FN_START, 4'd0, 16'hFFFF, 16'h0000, 8'd0, 16'd0, 16'd0));
    pending_items.push_back(mk_item(FN_MATCH, 4'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'hFFFF));
    pending_items.push_back(mk_item(FN_MATCH, 4'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'h0001));
    pending_items.push_back(mk_item(FN_STOP, 4'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0));
    pending_items.push_back(mk_item(FN_MATCH, 4'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'h1234));
    pending_items.push_back(mk_item(FN_MATCH, 4'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'h4321));
    pending_items.push_back(mk_item(FN_STOP, 4'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0));
    pending_items.push_back(mk_item(FN_START, 4'd9, 16'h0000, 16'hFFFF, 8'd0, 16'd0, 16'd0));
    pending_items.push_back(mk_item(FN_MATCH, 4'd9, 16'd0, 16'd0, 8'd0, 16'd0, 16'h0000));
    pending_items.push_back(mk_item(FN_STOP, 4'd9, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0));
    // servo extremes and range checks ahead of channel checks
    pending_items.push_back(mk_item(FN_ANGLE, 4'd7, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0));
    pending_items.push_back(mk_item(FN_ANGLE, 4'd6, 16'd0, 16'd0, 8'd180, 16'd0, 16'd0));
    pending_items.push_back(mk_item(FN_ANGLE, 4'd15, 16'd0, 16'd0, 8'd181, 16'd0, 16'd0));
    pending_items.push_back(mk_item(FN_ANGLE, 4'd3, 16'd0, 16'd0, 8'd255, 16'd0, 16'd0));
    pending_items.push_back(mk_item(FN_US, 4'd8, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0));
    pending_items.push_back(mk_item(FN_US, 4'd5, 16'd0, 16'd0, 8'd0, 16'd19000, 16'd0));
    pending_items.push_back(mk_item(FN_US, 4'd5, 16'd0, 16'd0, 8'd0, 16'd19001, 16'd0));
    pending_items.push_back(mk_item(FN_US, 4'd12, 16'd0, 16'd0, 8'd0, 16'hFFFF, 16'd0));
    // invalid channels and unknown functions
    pending_items.push_back(mk_item(FN_START, 4'd10, 16'h5555, 16'hAAAA, 8'd0, 16'd0, 16'd0));
    pending_items.push_back(mk_item(FN_MATCH, 4'd15, 16'd0, 16'd0, 8'd0, 16'd0, 16'hFFFF));
    pending_items.push_back(mk_item(FN_UNKNOWN_LO, 4'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0));
    pending_items.push_back(mk_item(FN_UNKNOWN_HI, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF,
                                    16'hFFFF, 16'hFFFF));
    // restart clears a pending stop
    pending_items.push_back(mk_item(FN_STOP, 4'd5, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0));
    pending_items.push_back(mk_item(FN_START, 4'd5, 16'h00FF, 16'hFF00, 8'd0, 16'd0, 16'd0));
    pending_items.push_back(mk_item(FN_MATCH, 4'd5, 16'd0, 16'd0, 8'd0, 16'd0, 16'h0100));
    wait_drained();

    foreach (settings[p]) begin
      write_unit_enable(settings[p]);
      added = 0;
      while (added < PHASE_ITEMS) begin
        if ($urandom_range(99, 0) < 70) added += add_wave_burst();
        else added += add_single();
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d item beats and %0d result beats over %0d unit enable settings",
             n_items, n_results, n_cfg);
    $display("%0d compare writes, %0d channel disables, %0d error results, %0d mismatches",
             n_writes, n_disables, n_errors_seen, mismatches);
    if (mismatches == 0) begin
      $display("multichannel_toggle_wave_generator_unit test passed");
    end else begin
      $display("multichannel_toggle_wave_generator_unit test failed");
    end
    $finish;
  end

endmodule
